// ----- rtl/htgs_pkg.sv -----
// ============================================================================
// htgs_pkg - shared types, constants and functions of the tripod gait sequencer
// Holds the rest angles, direction and register codes, the phase counter
// record and the arithmetic used to advance one tripod by one tick.
// ============================================================================
`default_nettype none

package htgs_pkg;

  localparam int NUM_LEGS   = 6;
  localparam int NUM_ANGLES = 12;

  // Angle order: leg1 elevation, leg1 rotation, leg2 elevation, ...
  localparam logic [7:0] REST_ANGLE [NUM_ANGLES] = '{
    8'd60, 8'd100, 8'd50, 8'd75, 8'd50, 8'd80,
    8'd65, 8'd40,  8'd80, 8'd25, 8'd90, 8'd60
  };

  localparam logic [7:0] ANGLE_MAX = 8'd180;

  // Configuration register reset values.
  localparam logic [3:0] LIFT_STEPS_RST  = 4'd10;
  localparam logic [5:0] SWING_STEPS_RST = 6'd30;
  localparam logic [5:0] LOWER_START_RST = 6'd20;
  localparam logic [2:0] LIFT_GAIN_RST   = 3'd2;

  typedef enum logic [2:0] {
    DIR_REST  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_BACK  = 3'd4
  } dir_t;

  typedef enum logic [2:0] {
    CFG_LIFT_STEPS  = 3'd0,
    CFG_SWING_STEPS = 3'd1,
    CFG_LOWER_START = 3'd2,
    CFG_LIFT_GAIN   = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [5:0] lift;
    logic [5:0] swing;
    logic [5:0] lower;
    logic [5:0] ret;
  } cnt_t;

  // Result of one tripod's phase step: which phases ran, intermediate
  // counter values seen by later phases, and the counters to store.
  typedef struct packed {
    logic       lift_act;
    logic       swing_act;
    logic       lower_act;
    logic       ret_act;
    logic [5:0] lift_v;
    logic [5:0] swing_v;
    cnt_t       nxt;
  } phase_t;

  function automatic phase_t tripod_phase(input cnt_t c, input logic [3:0] lsteps,
                                          input logic [5:0] ssteps,
                                          input logic [5:0] lstart);
    phase_t     p;
    logic [5:0] lower_v;
    logic [5:0] ret_v;
    p.lift_act  = (c.lift <= {2'b00, lsteps});
    p.lift_v    = p.lift_act ? c.lift + 6'd1 : c.lift;
    p.swing_act = (c.swing <= ssteps);
    p.swing_v   = p.swing_act ? c.swing + 6'd1 : c.swing;
    p.lower_act = (p.swing_v > lstart) && (c.lower <= {2'b00, lsteps});
    lower_v     = p.lower_act ? c.lower + 6'd1 : c.lower;
    p.ret_act   = (p.swing_v >= ssteps);
    ret_v       = p.ret_act ? c.ret + 6'd1 : c.ret;
    if (ret_v >= ssteps) begin
      p.nxt = '0;
    end else begin
      p.nxt.lift  = p.lift_v;
      p.nxt.swing = p.swing_v;
      p.nxt.lower = lower_v;
      p.nxt.ret   = ret_v;
    end
    return p;
  endfunction

  function automatic logic [7:0] sat_angle(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 12'sd0) begin
      r = 8'd0;
    end else if (v > $signed({4'd0, ANGLE_MAX})) begin
      r = ANGLE_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // rest + (a - b) * gain, saturated
  function automatic logic [7:0] elev_value(input logic [7:0] rest, input logic [5:0] a,
                                            input logic [5:0] b, input logic [2:0] gain);
    logic signed [11:0] d;
    logic signed [11:0] prod;
    d    = $signed({6'd0, a}) - $signed({6'd0, b});
    prod = d * $signed({9'd0, gain});
    return sat_angle($signed({4'd0, rest}) + prod);
  endfunction

  // rest +/- (a - b), saturated
  function automatic logic [7:0] rot_value(input logic [7:0] rest, input logic neg,
                                           input logic [5:0] a, input logic [5:0] b);
    logic signed [11:0] d;
    d = $signed({6'd0, a}) - $signed({6'd0, b});
    if (neg) begin
      d = -d;
    end
    return sat_angle($signed({4'd0, rest}) + d);
  endfunction

  // Leg numbering from 0; a set bit means the leg sweeps backward.
  function automatic logic leg_negative(input logic [2:0] dir, input int leg);
    logic n;
    unique case (dir)
      DIR_RIGHT: n = (leg < 3);
      DIR_LEFT:  n = (leg >= 3);
      DIR_BACK:  n = 1'b1;
      default:   n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hexapod_tripod_gait_sequencer_unit.sv -----
// ============================================================================
// hexapod_tripod_gait_sequencer_unit - six-leg tripod gait tick sequencer
// Takes one command word per gait tick and returns all twelve servo angles
// after that tick's update.
// ============================================================================
//
//   Channel  Direction  Handshake            Contents
//   in_      input      in_valid / in_stall  link flag, direction code
//   out_     output     out_valid / out_stall twelve 8-bit servo angles
//   cfg_     input      cfg_we               register index, write data
//
// Each word is held in the input register until the phase logic updates the
// angle and counter registers, which drive the result word directly. One word
// per cycle is taken while the result is not stalled.
// A stalled result holds the state and the input register, so one more
// word can wait in the input register behind it.
// Reset puts every angle at its rest value and clears the phase counters
// and the second tripod enable; the registers take their default values.
//
`default_nettype none

module hexapod_tripod_gait_sequencer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_link_ok,
  input  wire logic [2:0] in_direction,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_leg1_elevation,
  output logic [7:0]      out_leg1_rotation,
  output logic [7:0]      out_leg2_elevation,
  output logic [7:0]      out_leg2_rotation,
  output logic [7:0]      out_leg3_elevation,
  output logic [7:0]      out_leg3_rotation,
  output logic [7:0]      out_leg4_elevation,
  output logic [7:0]      out_leg4_rotation,
  output logic [7:0]      out_leg5_elevation,
  output logic [7:0]      out_leg5_rotation,
  output logic [7:0]      out_leg6_elevation,
  output logic [7:0]      out_leg6_rotation,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [5:0] cfg_data
);

  import htgs_pkg::*;

  // Configuration registers.
  logic [3:0] lift_steps_r;
  logic [5:0] swing_steps_r;
  logic [5:0] lower_start_r;
  logic [2:0] lift_gain_r;

  // Input stage.
  logic       in_valid_r;
  logic       link_r;
  logic [2:0] dir_r;

  // Gait state; the angle registers are also the result register.
  cnt_t       cnt_r   [2];
  cnt_t       cnt_nxt [2];
  logic       second_en_r;
  logic       second_en_nxt;
  logic [7:0] angle_r   [NUM_ANGLES];
  logic [7:0] angle_nxt [NUM_ANGLES];
  logic       out_valid_r;

  logic       in_accept;
  logic       fire;
  logic       is_rest;
  logic       is_move;
  logic       en_after_a;
  phase_t     ph [2];

  // The input stage moves on whenever the result slot is free or is being
  // taken this cycle.
  assign fire      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  assign is_rest = !link_r || (dir_r == DIR_REST);
  assign is_move = link_r && (dir_r == DIR_FWD || dir_r == DIR_RIGHT ||
                              dir_r == DIR_LEFT || dir_r == DIR_BACK);

  // Tripod B joins in the same tick that tripod A first reaches ground return.
  assign ph[0]      = tripod_phase(cnt_r[0], lift_steps_r, swing_steps_r, lower_start_r);
  assign ph[1]      = tripod_phase(cnt_r[1], lift_steps_r, swing_steps_r, lower_start_r);
  assign en_after_a = second_en_r || ph[0].ret_act;

  always_comb begin
    for (int i = 0; i < NUM_ANGLES; i++) begin
      angle_nxt[i] = angle_r[i];
    end
    cnt_nxt[0]    = cnt_r[0];
    cnt_nxt[1]    = cnt_r[1];
    second_en_nxt = second_en_r;

    if (is_rest) begin
      // Walk every servo one degree back toward its rest angle.
      for (int i = 0; i < NUM_ANGLES; i++) begin
        if (angle_r[i] > REST_ANGLE[i]) begin
          angle_nxt[i] = angle_r[i] - 8'd1;
        end else if (angle_r[i] < REST_ANGLE[i]) begin
          angle_nxt[i] = angle_r[i] + 8'd1;
        end
      end
      cnt_nxt[0]    = '0;
      cnt_nxt[1]    = '0;
      second_en_nxt = 1'b0;
    end else if (is_move) begin
      for (int t = 0; t < 2; t++) begin
        if (t == 0 || en_after_a) begin
          cnt_nxt[t] = ph[t].nxt;
          for (int k = 0; k < 3; k++) begin
            // Lowering overrides lifting, ground return overrides swing.
            if (ph[t].lower_act) begin
              angle_nxt[2*(t+2*k)] = elev_value(REST_ANGLE[2*(t+2*k)], ph[t].lift_v,
                                                cnt_r[t].lower, lift_gain_r);
            end else if (ph[t].lift_act) begin
              angle_nxt[2*(t+2*k)] = elev_value(REST_ANGLE[2*(t+2*k)], cnt_r[t].lift,
                                                6'd0, lift_gain_r);
            end
            if (ph[t].ret_act) begin
              angle_nxt[2*(t+2*k)+1] = rot_value(REST_ANGLE[2*(t+2*k)+1],
                                                 leg_negative(dir_r, t+2*k),
                                                 ph[t].swing_v, cnt_r[t].ret);
            end else if (ph[t].swing_act) begin
              angle_nxt[2*(t+2*k)+1] = rot_value(REST_ANGLE[2*(t+2*k)+1],
                                                 leg_negative(dir_r, t+2*k),
                                                 cnt_r[t].swing, 6'd0);
            end
          end
        end
      end
      second_en_nxt = en_after_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_steps_r  <= LIFT_STEPS_RST;
      swing_steps_r <= SWING_STEPS_RST;
      lower_start_r <= LOWER_START_RST;
      lift_gain_r   <= LIFT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIFT_STEPS:  lift_steps_r  <= cfg_data[3:0];
        CFG_SWING_STEPS: swing_steps_r <= cfg_data;
        CFG_LOWER_START: lower_start_r <= cfg_data;
        CFG_LIFT_GAIN:   lift_gain_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      second_en_r <= 1'b0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      for (int i = 0; i < NUM_ANGLES; i++) begin
        angle_r[i] <= REST_ANGLE[i];
      end
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        second_en_r <= second_en_nxt;
        cnt_r[0]    <= cnt_nxt[0];
        cnt_r[1]    <= cnt_nxt[1];
        for (int i = 0; i < NUM_ANGLES; i++) begin
          angle_r[i] <= angle_nxt[i];
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      link_r <= in_link_ok;
      dir_r  <= in_direction;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_leg1_elevation = angle_r[0];
  assign out_leg1_rotation  = angle_r[1];
  assign out_leg2_elevation = angle_r[2];
  assign out_leg2_rotation  = angle_r[3];
  assign out_leg3_elevation = angle_r[4];
  assign out_leg3_rotation  = angle_r[5];
  assign out_leg4_elevation = angle_r[6];
  assign out_leg4_rotation  = angle_r[7];
  assign out_leg5_elevation = angle_r[8];
  assign out_leg5_rotation  = angle_r[9];
  assign out_leg6_elevation = angle_r[10];
  assign out_leg6_rotation  = angle_r[11];

  // A new result only appears when an input word moved out of the input stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result word without a pending input word");

  // A rest tick or a lost link always leaves tripod B disabled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_rest) |=> !second_en_r)
    else $error("tripod B still enabled after a rest tick");

  // Tripod B never holds a phase count while it is disabled.
  assert property (@(posedge clk) disable iff (!rst_n)
    !second_en_r |-> (cnt_r[1] == '0))
    else $error("tripod B counters moved while disabled");

  // An empty input stage never pushes back.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with an empty input stage");

  // While a result waits, the gait state holds still.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(second_en_r) && $stable(cnt_r[0]))
    else $error("gait state changed under a stalled result");

endmodule

`default_nettype wire
